// ===== hdl/two_level_lru_cache_tag_tracker_defines.svh =====
`ifndef TWO_LEVEL_LRU_CACHE_TAG_TRACKER_DEFINES_SVH
`define TWO_LEVEL_LRU_CACHE_TAG_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ltt_pkg.sv =====
`default_nettype none
package ltt_pkg;
  localparam int ADDR_BITS  = 13;
  localparam int MAX_WAYS   = 16;
  localparam int WAY_AW     = $clog2(MAX_WAYS);
  localparam int L1_LINES   = 1024;
  localparam int L2_LINES   = 4096;
  localparam int L1_LINE_AW = $clog2(L1_LINES);
  localparam int L2_LINE_AW = $clog2(L2_LINES);
  localparam int L1_GROUPS  = L1_LINES / MAX_WAYS;
  localparam int L2_GROUPS  = L2_LINES / MAX_WAYS;
  localparam int TAG_W      = 14;
  localparam int AGE_W      = 4;

  localparam logic [1:0] ST_STORE = 2'd0;
  localparam logic [1:0] ST_HIT   = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;

  localparam logic [2:0] REG_L2_EN    = 3'd0;
  localparam logic [2:0] REG_L1_WAYS  = 3'd1;
  localparam logic [2:0] REG_L1_BLOCK = 3'd2;
  localparam logic [2:0] REG_L1_ROWS  = 3'd3;
  localparam logic [2:0] REG_L2_WAYS  = 3'd4;
  localparam logic [2:0] REG_L2_BLOCK = 3'd5;
  localparam logic [2:0] REG_L2_ROWS  = 3'd6;

  typedef struct packed {
    logic             vld;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } lane_t;

  typedef lane_t [MAX_WAYS-1:0] group_t;
endpackage
`default_nettype wire

// ===== hdl/two_level_lru_cache_tag_tracker.sv =====
`default_nettype none
`include "two_level_lru_cache_tag_tracker_defines.svh"
// Tag-only model of a one- or two-level set-associative cache with true LRU.
// Each level keeps its sets in a synchronous RAM holding sixteen
// lines per word; an access reads the word, updates tags and ages, and
// writes it back. An access passes through a read state, a first-level
// update state and, when the second level is visited too, a second-level
// update state; each update state waits while the result channel stalls.
// A new access is accepted only when idle. Any write to a defined register
// flushes both levels at once through per-word valid flags.
module two_level_lru_cache_tag_tracker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // address[12:0], pc[25:13], zero fill
  input  wire logic [0:0]  in_tuser,    // req_type[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,   // pc_out[12:0], addr_out[25:13], row[37:26], zero fill
  output logic      [2:0]  out_tuser,   // level[0], status[2:1]
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  localparam int AB   = ltt_pkg::ADDR_BITS;
  localparam int G1AW = $clog2(ltt_pkg::L1_GROUPS);
  localparam int G2AW = $clog2(ltt_pkg::L2_GROUPS);
  localparam int GW   = $bits(ltt_pkg::group_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EX1  = 2'd2;
  localparam logic [1:0] S_EX2  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       l2_en_r;
  logic [2:0] l1_ways_r, l1_block_r, l2_ways_r, l2_block_r;
  logic [3:0] l1_rows_r, l2_rows_r;
  logic       cfg_wr;
  logic       cfg_hit;

  logic          store_r;
  logic [AB-1:0] addr_r, pc_r;

  logic [ltt_pkg::L1_GROUPS-1:0] g1_vld_r;
  logic [ltt_pkg::L2_GROUPS-1:0] g2_vld_r;

  logic [2:0]                       w1, w2;
  logic [3:0]                       r1, r2;
  logic [AB-1:0]                    blk1, blk2, rmask1, rmask2;
  logic [11:0]                      row1, row2;
  logic [ltt_pkg::TAG_W-1:0]        tag1, tag2;
  logic [15:0]                      base1, base2;
  logic [G1AW-1:0]                  grp1;
  logic [G2AW-1:0]                  grp2;
  ltt_pkg::group_t                  rd1, rd2, wr1, wr2;
  logic                             hit1, hit2, go2;
  logic                             out_free, fire1, fire2;

  logic                             out_valid_r;
  logic                             out_level_r, out_last_r;
  logic [1:0]                       out_status_r;
  logic [AB-1:0]                    out_pc_r, out_addr_r;
  logic [11:0]                      out_row_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_hit    = cfg_wr && (cfg_paddr[4:2] != 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l2_en_r    <= 1'b0;
      l1_ways_r  <= 3'd0;
      l1_block_r <= 3'd0;
      l1_rows_r  <= 4'd4;
      l2_ways_r  <= 3'd0;
      l2_block_r <= 3'd0;
      l2_rows_r  <= 4'd4;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        ltt_pkg::REG_L2_EN:    l2_en_r    <= cfg_pwdata[0];
        ltt_pkg::REG_L1_WAYS:  l1_ways_r  <= cfg_pwdata[2:0];
        ltt_pkg::REG_L1_BLOCK: l1_block_r <= cfg_pwdata[2:0];
        ltt_pkg::REG_L1_ROWS:  l1_rows_r  <= cfg_pwdata[3:0];
        ltt_pkg::REG_L2_WAYS:  l2_ways_r  <= cfg_pwdata[2:0];
        ltt_pkg::REG_L2_BLOCK: l2_block_r <= cfg_pwdata[2:0];
        ltt_pkg::REG_L2_ROWS:  l2_rows_r  <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      ltt_pkg::REG_L2_EN:    cfg_prdata = {31'd0, l2_en_r};
      ltt_pkg::REG_L1_WAYS:  cfg_prdata = {29'd0, l1_ways_r};
      ltt_pkg::REG_L1_BLOCK: cfg_prdata = {29'd0, l1_block_r};
      ltt_pkg::REG_L1_ROWS:  cfg_prdata = {28'd0, l1_rows_r};
      ltt_pkg::REG_L2_WAYS:  cfg_prdata = {29'd0, l2_ways_r};
      ltt_pkg::REG_L2_BLOCK: cfg_prdata = {29'd0, l2_block_r};
      ltt_pkg::REG_L2_ROWS:  cfg_prdata = {28'd0, l2_rows_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  always_comb begin
    w1 = (l1_ways_r > 3'(ltt_pkg::WAY_AW)) ? 3'(ltt_pkg::WAY_AW) : l1_ways_r;
    w2 = (l2_ways_r > 3'(ltt_pkg::WAY_AW)) ? 3'(ltt_pkg::WAY_AW) : l2_ways_r;
    r1 = (l1_rows_r > 4'(ltt_pkg::L1_LINE_AW) - 4'(w1)) ?
         4'(ltt_pkg::L1_LINE_AW) - 4'(w1) : l1_rows_r;
    r2 = (l2_rows_r > 4'(ltt_pkg::L2_LINE_AW) - 4'(w2)) ?
         4'(ltt_pkg::L2_LINE_AW) - 4'(w2) : l2_rows_r;
    blk1   = addr_r >> l1_block_r;
    blk2   = addr_r >> l2_block_r;
    rmask1 = AB'((17'd1 << r1) - 17'd1);
    rmask2 = AB'((17'd1 << r2) - 17'd1);
    row1   = 12'(blk1 & rmask1);
    row2   = 12'(blk2 & rmask2);
    tag1   = ltt_pkg::TAG_W'(blk1 >> r1);
    tag2   = ltt_pkg::TAG_W'(blk2 >> r2);
    base1  = 16'(row1) << w1;
    base2  = 16'(row2) << w2;
    grp1   = base1[ltt_pkg::L1_LINE_AW-1:ltt_pkg::WAY_AW];
    grp2   = base2[ltt_pkg::L2_LINE_AW-1:ltt_pkg::WAY_AW];
  end

  ltt_ram #(.DEPTH(ltt_pkg::L1_GROUPS), .WIDTH(GW)) u_l1_ram (
    .clk(clk), .raddr(grp1), .rdata(rd1), .we(fire1), .waddr(grp1), .wdata(wr1)
  );

  ltt_ram #(.DEPTH(ltt_pkg::L2_GROUPS), .WIDTH(GW)) u_l2_ram (
    .clk(clk), .raddr(grp2), .rdata(rd2), .we(fire2), .waddr(grp2), .wdata(wr2)
  );

  ltt_set_update u_l1_upd (
    .rd_data(rd1), .grp_vld(g1_vld_r[grp1]), .wlog(w1),
    .lane_base(base1[ltt_pkg::WAY_AW-1:0]), .tag(tag1), .hit(hit1), .wr_data(wr1)
  );

  ltt_set_update u_l2_upd (
    .rd_data(rd2), .grp_vld(g2_vld_r[grp2]), .wlog(w2),
    .lane_base(base2[ltt_pkg::WAY_AW-1:0]), .tag(tag2), .hit(hit2), .wr_data(wr2)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign fire1     = (state_r == S_EX1) && out_free;
  assign fire2     = (state_r == S_EX2) && out_free;
  assign go2       = l2_en_r && (!hit1 || store_r);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_RD;
      S_RD:   state_nxt = S_EX1;
      S_EX1:  if (out_free) state_nxt = go2 ? S_EX2 : S_IDLE;
      S_EX2:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      g1_vld_r    <= '0;
      g2_vld_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (fire1 || fire2) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_hit) begin
        g1_vld_r <= '0;
        g2_vld_r <= '0;
      end else begin
        if (fire1) g1_vld_r[grp1] <= 1'b1;
        if (fire2) g2_vld_r[grp2] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      store_r <= in_tuser[0];
      addr_r  <= in_tdata[AB-1:0];
      pc_r    <= in_tdata[2*AB-1:AB];
    end
    if (fire1) begin
      out_level_r  <= 1'b0;
      out_status_r <= store_r ? ltt_pkg::ST_STORE : (hit1 ? ltt_pkg::ST_HIT : ltt_pkg::ST_MISS);
      out_row_r    <= row1;
      out_last_r   <= !go2;
      out_pc_r     <= pc_r;
      out_addr_r   <= addr_r;
    end else if (fire2) begin
      out_level_r  <= 1'b1;
      out_status_r <= store_r ? ltt_pkg::ST_STORE : (hit2 ? ltt_pkg::ST_HIT : ltt_pkg::ST_MISS);
      out_row_r    <= row2;
      out_last_r   <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_row_r, out_addr_r, out_pc_r};
  assign out_tuser  = {out_status_r, out_level_r};
  assign out_tlast  = out_last_r;

  `LTT_ASSERT_NEXT(a_accept_reads, in_tvalid && in_tready, state_r == S_RD, "accept must start a read")
  `LTT_ASSERT_NOW(a_l2_needs_enable, state_r == S_EX2, l2_en_r, "second level visited while disabled")
  `LTT_ASSERT_NOW(a_l2_is_last, out_tvalid && out_tuser[0], out_tlast, "second level result not last")
endmodule
`default_nettype wire

// ===== hdl/ltt_ram.sv =====
`default_nettype none
module ltt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/ltt_set_update.sv =====
`default_nettype none
module ltt_set_update (
  input  wire ltt_pkg::group_t                 rd_data,
  input  wire logic                            grp_vld,
  input  wire logic [2:0]                      wlog,
  input  wire logic [ltt_pkg::WAY_AW-1:0]      lane_base,
  input  wire logic [ltt_pkg::TAG_W-1:0]       tag,
  output logic                                 hit,
  output ltt_pkg::group_t                      wr_data
);
  ltt_pkg::group_t              eff;
  logic [ltt_pkg::WAY_AW-1:0]   mask;
  logic [ltt_pkg::MAX_WAYS-1:0] inrow;
  logic [ltt_pkg::MAX_WAYS-1:0] match;
  logic [ltt_pkg::MAX_WAYS-1:0] oldest;
  logic [ltt_pkg::WAY_AW-1:0]   hit_lane;
  logic [ltt_pkg::WAY_AW-1:0]   lru_lane;
  logic [ltt_pkg::WAY_AW-1:0]   pick;
  logic [ltt_pkg::AGE_W-1:0]    old_age;

  always_comb begin
    mask = ltt_pkg::WAY_AW'((ltt_pkg::MAX_WAYS'(1) << wlog) - 1);
    for (int j = 0; j < ltt_pkg::MAX_WAYS; j++) begin
      if (grp_vld) begin
        eff[j] = rd_data[j];
      end else begin
        eff[j].vld = 1'b0;
        eff[j].tag = '0;
        eff[j].age = ltt_pkg::AGE_W'(ltt_pkg::WAY_AW'(j) & mask);
      end
      inrow[j]  = (ltt_pkg::WAY_AW'(j) & ~mask) == lane_base;
      match[j]  = inrow[j] && eff[j].vld && (eff[j].tag == tag);
      oldest[j] = inrow[j] && (eff[j].age == '0);
    end
    hit_lane = lane_base;
    lru_lane = lane_base;
    for (int j = ltt_pkg::MAX_WAYS - 1; j >= 0; j--) begin
      if (match[j]) begin
        hit_lane = ltt_pkg::WAY_AW'(j);
      end
      if (oldest[j]) begin
        lru_lane = ltt_pkg::WAY_AW'(j);
      end
    end
    hit     = |match;
    pick    = hit ? hit_lane : lru_lane;
    old_age = eff[pick].age;
    for (int j = 0; j < ltt_pkg::MAX_WAYS; j++) begin
      wr_data[j] = eff[j];
      if (inrow[j]) begin
        if (ltt_pkg::WAY_AW'(j) == pick) begin
          wr_data[j].vld = 1'b1;
          wr_data[j].tag = tag;
          wr_data[j].age = ltt_pkg::AGE_W'(mask);
        end else if (eff[j].age > old_age) begin
          wr_data[j].age = eff[j].age - 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb_two_level_lru_cache_tag_tracker.sv =====
`timescale 1ns / 1ps
module tb_two_level_lru_cache_tag_tracker;

  typedef struct {
    logic        is_store;
    logic [12:0] addr;
    logic [12:0] pc;
  } access_t;

  typedef struct {
    logic        lvl;
    logic [1:0]  status;
    logic [12:0] pc;
    logic [12:0] addr;
    logic [11:0] row;
    logic        last;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  access_t pending_accesses[$];
  lookup_t expected_lookups[$];
  int      errors = 0;
  int      cycles = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  // Predictor state: index 0 is the first level, 1 the second.
  logic [3:0]  geom[7];
  logic [14:0] line_tag[2][4096];
  logic [3:0]  line_age[2][4096];
  int          level_lines[2] = '{1024, 4096};

  two_level_lru_cache_tag_tracker dut (.*);

  always #10 clk = ~clk;

  function automatic int fitted_ways(int w);
    while (w > 0 && (1 << w) > ltt_pkg::MAX_WAYS) w--;
    return w;
  endfunction

  function automatic int fitted_rows(int r, int w, int lines);
    while (r > 0 && (1 << (r + w)) > lines) r--;
    return r;
  endfunction

  function automatic void flush_tags();
    int mask;
    for (int l = 0; l < 2; l++) begin
      mask = (1 << fitted_ways(l == 0 ? geom[ltt_pkg::REG_L1_WAYS]
                                      : geom[ltt_pkg::REG_L2_WAYS])) - 1;
      for (int i = 0; i < level_lines[l]; i++) begin
        line_tag[l][i] = '0;
        line_age[l][i] = 4'(i & mask);
      end
    end
  endfunction

  function automatic bit lookup_level(int l, logic [12:0] addr, output logic [11:0] row_o);
    int wlog, rlog, blog, ways, lines, base, pick, li;
    int unsigned blk, row, tag;
    bit hit;
    logic [3:0] old;
    lines = level_lines[l];
    wlog = fitted_ways(l == 0 ? geom[ltt_pkg::REG_L1_WAYS] : geom[ltt_pkg::REG_L2_WAYS]);
    blog = l == 0 ? geom[ltt_pkg::REG_L1_BLOCK] : geom[ltt_pkg::REG_L2_BLOCK];
    rlog = fitted_rows(l == 0 ? geom[ltt_pkg::REG_L1_ROWS] : geom[ltt_pkg::REG_L2_ROWS],
                       wlog, lines);
    ways = 1 << wlog;
    blk = addr >> blog;
    row = blk & ((1 << rlog) - 1);
    tag = blk >> rlog;
    base = row << wlog;
    hit = 0;
    pick = 0;
    for (int w = 0; w < ways; w++) begin
      li = (base + w) % lines;
      if (!hit && line_tag[l][li][14] && line_tag[l][li][13:0] == 14'(tag)) begin
        hit = 1;
        pick = w;
      end
    end
    if (!hit) begin
      for (int w = ways - 1; w >= 0; w--)
        if (line_age[l][(base + w) % lines] == 0) pick = w;
    end
    old = line_age[l][(base + pick) % lines];
    for (int w = 0; w < ways; w++) begin
      li = (base + w) % lines;
      if (line_age[l][li] > old) line_age[l][li] = line_age[l][li] - 4'd1;
    end
    line_age[l][(base + pick) % lines] = 4'(ways - 1);
    line_tag[l][(base + pick) % lines] = {1'b1, 14'(tag)};
    row_o = 12'(row);
    return hit;
  endfunction

  function automatic void predict_access(access_t a);
    lookup_t r;
    bit hit;
    bit go2;
    hit = lookup_level(0, a.addr, r.row);
    go2 = geom[ltt_pkg::REG_L2_EN][0] && (!hit || a.is_store);
    r.lvl = 1'b0;
    r.status = a.is_store ? ltt_pkg::ST_STORE : (hit ? ltt_pkg::ST_HIT : ltt_pkg::ST_MISS);
    r.pc = a.pc;
    r.addr = a.addr;
    r.last = !go2;
    expected_lookups = {expected_lookups, r};
    if (go2) begin
      hit = lookup_level(1, a.addr, r.row);
      r.lvl = 1'b1;
      r.status = a.is_store ? ltt_pkg::ST_STORE : (hit ? ltt_pkg::ST_HIT : ltt_pkg::ST_MISS);
      r.last = 1'b1;
      expected_lookups = {expected_lookups, r};
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        predict_access('{in_tuser[0], in_tdata[12:0], in_tdata[25:13]});
      if (!in_tvalid || in_tready) begin
        if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          access_t a;
          a = pending_accesses.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {6'b0, a.pc, a.addr};
          in_tuser <= a.is_store;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch($sformatf("unexpected result tdata=%h tuser=%h",
                                    out_tdata, out_tuser));
        end else begin
          lookup_t e;
          e = expected_lookups.pop_front();
          if (out_tuser[0] !== e.lvl)
            report_mismatch($sformatf("level %b, want %b", out_tuser[0], e.lvl));
          if (out_tuser[2:1] !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", out_tuser[2:1], e.status));
          if (out_tdata[12:0] !== e.pc)
            report_mismatch($sformatf("pc %h, want %h", out_tdata[12:0], e.pc));
          if (out_tdata[25:13] !== e.addr)
            report_mismatch($sformatf("addr %h, want %h", out_tdata[25:13], e.addr));
          if (out_tdata[37:26] !== e.row)
            report_mismatch($sformatf("row %h, want %h", out_tdata[37:26], e.row));
          if (out_tlast !== e.last)
            report_mismatch($sformatf("tlast %b, want %b", out_tlast, e.last));
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (cycles > 600000) begin
      $display("two_level_lru_cache_tag_tracker verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [3:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx) << 2;
    cfg_pwdata <= 32'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    geom[idx] = val;
    flush_tags();
  endtask

  // Sampled on the falling edge so the driver's updates have settled.
  task automatic drain();
    while (pending_accesses.size() > 0 || in_tvalid || expected_lookups.size() > 0)
      @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic push_access(bit st, logic [12:0] a, logic [12:0] p);
    access_t item;
    item = '{st, a, p};
    pending_accesses = {pending_accesses, item};
  endtask

  task automatic random_accesses(int n);
    logic [12:0] hot[16];
    int k;
    foreach (hot[i]) hot[i] = 13'($urandom);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      push_access(1'($urandom_range(1)),
                  k < 65 ? hot[$urandom_range(15)] ^ 13'($urandom_range(3)) : 13'($urandom),
                  13'($urandom));
    end
  endtask

  initial begin
    logic [3:0] settings[8][7] = '{
      '{1, 2, 1, 3, 3, 2, 4},
      '{1, 7, 0, 15, 7, 0, 15},
      '{0, 0, 0, 0, 0, 0, 0},
      '{1, 0, 6, 10, 0, 6, 12},
      '{1, 4, 0, 6, 4, 0, 8},
      '{1, 1, 2, 2, 2, 3, 5},
      '{1, 7, 7, 15, 7, 7, 15},
      '{0, 3, 1, 4, 1, 1, 4}};
    geom = '{0, 0, 0, 4, 0, 0, 4};
    flush_tags();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    push_access(0, 13'd0, 13'd0);
    push_access(0, 13'd0, 13'h1fff);
    push_access(1, 13'h1fff, 13'h1fff);
    push_access(0, 13'h1fff, 13'd0);
    push_access(1, 13'd16, 13'h0aaa);
    push_access(0, 13'd16, 13'h1555);
    drain();
    for (int i = 0; i < 7; i++) write_reg(3'(i), settings[0][i]);
    push_access(0, 13'd0, 13'd1);
    push_access(0, 13'd64, 13'd2);
    push_access(0, 13'd128, 13'd3);
    push_access(0, 13'd0, 13'd4);
    push_access(1, 13'd192, 13'd5);
    push_access(0, 13'd256, 13'd6);
    push_access(0, 13'd320, 13'd7);
    push_access(0, 13'd64, 13'd8);
    push_access(1, 13'h1fff, 13'd9);
    push_access(0, 13'h1fff, 13'd10);
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (ph < 8) begin
        for (int i = 0; i < 7; i++) write_reg(3'(i), settings[ph][i]);
      end else begin
        write_reg(ltt_pkg::REG_L2_EN, 4'($urandom_range(1)));
        write_reg(ltt_pkg::REG_L1_WAYS, 4'($urandom_range(7)));
        write_reg(ltt_pkg::REG_L1_BLOCK, 4'($urandom_range(7)));
        write_reg(ltt_pkg::REG_L1_ROWS, 4'($urandom_range(15)));
        write_reg(ltt_pkg::REG_L2_WAYS, 4'($urandom_range(7)));
        write_reg(ltt_pkg::REG_L2_BLOCK, 4'($urandom_range(7)));
        write_reg(ltt_pkg::REG_L2_ROWS, 4'($urandom_range(15)));
      end
      random_accesses(52);
      drain();
    end

    if (errors == 0) begin
      $display("two_level_lru_cache_tag_tracker verification clean");
    end else begin
      $display("two_level_lru_cache_tag_tracker verification failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ltt_pkg.sv
hdl/ltt_ram.sv
hdl/ltt_set_update.sv
hdl/two_level_lru_cache_tag_tracker.sv
tb/sv/tb_two_level_lru_cache_tag_tracker.sv
